// ===== rtl/stepper_phase_sequencer_ramp_macros.svh =====
// Assertion macros for the stepper phase sequencer.
// Included by the top level; needs clk and rst_n in scope.
`ifndef STEPPER_PHASE_SEQUENCER_RAMP_MACROS_SVH
`define STEPPER_PHASE_SEQUENCER_RAMP_MACROS_SVH
`ifndef SYNTHESIS
`define SPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sps: implication check failed");
`define SPS_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sps: forbidden condition seen");
`else
`define SPS_ASSERT_IMP(label, ante, cons)
`define SPS_ASSERT_NEVER(label, expr)
`endif
`endif

// ===== rtl/sps_pkg.sv =====
// Shared types and constants for the stepper phase sequencer.
// No dependencies.
package sps_pkg;

    localparam int DIV_W  = 11;
    localparam int TICK_W = 8;
    localparam int SPD_W  = 8;
    localparam int CNT_W  = 4;

    localparam logic [7:0]       RING_RESET = 8'h88;
    localparam logic [SPD_W-1:0] SPEED_MAX  = 8'd255;
    localparam logic [SPD_W-1:0] BRAKE_DROP = 8'd2;
    localparam int               RATE_SCALE = 5;
    localparam logic [DIV_W-1:0] RATE_NUM   = DIV_W'(255 * RATE_SCALE);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SPEED = 2'd1,
        OP_ACCEL = 2'd2,
        OP_BRAKE = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_QUO  = 5'b00010,
        S_REM  = 5'b00100,
        S_UPD  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

endpackage

// ===== rtl/sps_div_step.sv =====
// One restoring shift-subtract step, shared by the quotient and remainder passes.
// Depends on sps_pkg.
module sps_div_step
    import sps_pkg::*;
(
    input  logic [DIV_W-1:0] rem_in,
    input  logic             bit_in,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] rem_out,
    output logic             q_bit
);

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;

    assign trial   = {rem_in, bit_in};
    assign diff    = trial - {1'b0, divisor};
    assign q_bit   = (trial >= {1'b0, divisor});
    assign rem_out = q_bit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

endmodule

// ===== rtl/stepper_phase_sequencer_ramp.sv =====
// Stepper phase sequencer with speed ramp: sequencer, state and output register.
// Depends on sps_pkg, sps_div_step and stepper_phase_sequencer_ramp_macros.svh.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tuser opcode, tdata value
//  m_*     | out | m_tvalid/m_tready | tdata coil, speed, accel, brake
//
// A tick runs 11 shift-subtract steps for 1275 div speed and then 8 for
// the counter remainder, all on the one shared step unit. A tick at speed zero
// skips both passes; a command goes straight to S_FIN. Reset leaves the block ready at once.
// A stalled result holds in the output register; the next item is taken meanwhile.
`include "stepper_phase_sequencer_ramp_macros.svh"
module stepper_phase_sequencer_ramp
    import sps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [3:0] coil_pattern, [11:4] speed_now,
                                   // [12] accelerating, [13] braking, [15:14] zero
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   dvd_reg, dvd_next;
    logic [7:0]         ring_reg, ring_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [SPD_W-1:0]   speed_reg, speed_next;
    logic               accel_reg, accel_next;
    logic               brake_reg, brake_next;
    logic               is_tick_reg, is_tick_next;
    logic [3:0]         coil_reg, coil_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_data_reg, out_data_next;

    logic [DIV_W-1:0]   step_divisor;
    logic [DIV_W-1:0]   step_rem;
    logic               step_q;
    logic               accept;
    opcode_t            opcode;
    logic [SPD_W-1:0]   ramp_speed;

    assign opcode   = opcode_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign step_divisor = (state_reg == S_QUO) ? {{(DIV_W-SPD_W){1'b0}}, speed_reg} : quo_reg;

    sps_div_step u_step (
        .rem_in  (rem_reg),
        .bit_in  (dvd_reg[DIV_W-1]),
        .divisor (step_divisor),
        .rem_out (step_rem),
        .q_bit   (step_q)
    );

    always_comb
    begin
        ramp_speed = speed_reg;
        if (accel_reg && (ramp_speed != SPEED_MAX))
        begin
            ramp_speed = ramp_speed + 8'd1;
        end
        if (brake_reg)
        begin
            ramp_speed = (ramp_speed > BRAKE_DROP) ? (ramp_speed - BRAKE_DROP) : '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvd_next       = dvd_reg;
        ring_next      = ring_reg;
        tick_next      = tick_reg;
        speed_next     = speed_reg;
        accel_next     = accel_reg;
        brake_next     = brake_reg;
        is_tick_next   = is_tick_reg;
        coil_next      = coil_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    coil_next    = '0;
                    is_tick_next = 1'b0;
                    state_next   = S_FIN;
                    unique case (opcode)
                        OP_TICK:
                        begin
                            coil_next    = ring_reg[3:0];
                            tick_next    = tick_reg + 8'd1;
                            is_tick_next = 1'b1;
                            rem_next     = '0;
                            quo_next     = '0;
                            dvd_next     = RATE_NUM;
                            cnt_next     = CNT_W'(DIV_W - 1);
                            state_next   = (speed_reg != '0) ? S_QUO : S_UPD;
                        end
                        OP_SPEED: speed_next = s_tdata;
                        OP_ACCEL: accel_next = !brake_reg && (s_tdata != '0);
                        OP_BRAKE:
                        begin
                            if (s_tdata != '0)
                            begin
                                accel_next = 1'b0;
                            end
                            brake_next = (s_tdata != '0);
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_QUO:
            begin
                rem_next = step_rem;
                quo_next = {quo_reg[DIV_W-2:0], step_q};
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    dvd_next   = {tick_reg, {(DIV_W-TICK_W){1'b0}}};
                    cnt_next   = CNT_W'(TICK_W - 1);
                    state_next = S_REM;
                end
            end
            S_REM:
            begin
                rem_next = step_rem;
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if ((speed_reg != '0) && (rem_reg == '0))
                begin
                    ring_next = {ring_reg[0], ring_reg[7:1]};
                end
                speed_next = ramp_speed;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, brake_reg, accel_reg, speed_reg, coil_reg};
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            dvd_reg       <= '0;
            ring_reg      <= RING_RESET;
            tick_reg      <= '0;
            speed_reg     <= '0;
            accel_reg     <= 1'b0;
            brake_reg     <= 1'b0;
            is_tick_reg   <= 1'b0;
            coil_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            dvd_reg       <= dvd_next;
            ring_reg      <= ring_next;
            tick_reg      <= tick_next;
            speed_reg     <= speed_next;
            accel_reg     <= accel_next;
            brake_reg     <= brake_next;
            is_tick_reg   <= is_tick_next;
            coil_reg      <= coil_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    `SPS_ASSERT_IMP(a_quo_speed_nonzero, state_reg == S_QUO, speed_reg != '0 && is_tick_reg)
    `SPS_ASSERT_IMP(a_rem_divisor_min, state_reg == S_REM, quo_reg >= DIV_W'(RATE_SCALE))
    `SPS_ASSERT_IMP(a_rem_below_divisor, state_reg == S_REM, rem_reg < quo_reg)
    `SPS_ASSERT_NEVER(a_accel_brake_excl, accel_reg && brake_reg)

endmodule
